// File: hdl/slfr_pkg.sv
// shared types, constants and widths for the subtractive lagged-fibonacci generator
`timescale 1ns / 1ps

package slfr_pkg;

    // field widths
    localparam int VAL_W   = 30;           // table value and modulus width
    localparam int MOD_W   = VAL_W + 1;    // effective modulus, may be 2^30
    localparam int SEED_W  = 31;
    localparam int FRAC_W  = 32;
    localparam int ENTRY_W = 32;           // stored table entries, two's complement
    localparam int ALU_W   = 34;           // shared unit datapath

    // scheme constants
    localparam int TABLE_LEN     = 55;
    localparam int SPREAD_STRIDE = 21;
    localparam int LAG_GAP       = 30;
    localparam int TRAIL_START   = 31;
    localparam int MIX_PASSES    = 4;

    localparam int DEF_WARMUP_DRAWS = 100;

    // table index and pointer widths
    localparam int IDX_W = $clog2(TABLE_LEN);
    localparam int PTR_W = $clog2(TABLE_LEN + 1);

    // configuration registers
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = VAL_W;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_OFFSET = 1'd1;
    localparam logic [VAL_W-1:0] MODULUS_RESET     = 30'd1000000000;
    localparam logic [VAL_W-1:0] SEED_OFFSET_RESET = 30'd161803398;

    // input function codes
    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_SEED = 1'b1;

    // shared unit operations
    typedef enum logic {
        ALU_SUB_MOD  = 1'b0,   // a - b, modulus added back when negative
        ALU_DIV_STEP = 1'b1    // restoring division step: a - modulus if it fits
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0]   res;
        logic               fits;   // difference was not negative
    } t_alu_rsp;

endpackage

// File: hdl/slfr_in_if.sv
// input channel: function code and seed with valid/ready handshake
`timescale 1ns / 1ps

interface slfr_in_if;
    import slfr_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [SEED_W-1:0] seed_value;

    modport source (output valid, output func, output seed_value, input ready);
    modport sink   (input valid, input func, input seed_value, output ready);
endinterface

// File: hdl/slfr_out_if.sv
// output channel: random value and fraction with valid/ready handshake
`timescale 1ns / 1ps

interface slfr_out_if;
    import slfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  value;
    logic [FRAC_W-1:0] fraction;

    modport source (output valid, output value, output fraction, input ready);
    modport sink   (input valid, input value, input fraction, output ready);
endinterface

// File: hdl/subtractive_lagged_fibonacci_rng.sv
// Subtractive lagged-Fibonacci random number generator (55-entry table, lags 55 and 24).
// A seed transaction (func 1) rebuilds the table and gives no result, in these steps:
// the start value, 31 division steps for its remainder, 55 table writes for the spread,
// four mixing passes and WARMUP_DRAWS discarded warm-up draws. A draw transaction
// (func 0) returns one value and its Q0.32 fraction of the modulus after the table
// read and write, a range check and 32 division steps for the fraction (the fraction
// saturates to all ones without division when the value is not below the modulus).
// A draw before any seed first builds the table from seed 0 without warm-up. The
// steps are serialised by the single shared subtract unit, used once per cycle, and
// by the table memory's one write port. A new transaction is taken while a result
// waits at the output register. A modulus of 0 acts as 2^30.
`timescale 1ns / 1ps

module subtractive_lagged_fibonacci_rng #(
    parameter int WARMUP_DRAWS = slfr_pkg::DEF_WARMUP_DRAWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [slfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [slfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    slfr_in_if.sink                         i_in,
    slfr_out_if.source                      o_out
);
    import slfr_pkg::*;

    localparam int WU_W  = $clog2(WARMUP_DRAWS + 1) < 1 ? 1 : $clog2(WARMUP_DRAWS + 1);
    localparam int CNT_W = $clog2(TABLE_LEN);
    localparam int PASS_W = $clog2(MIX_PASSES) < 1 ? 1 : $clog2(MIX_PASSES);

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ABS     = 4'd1;
    localparam logic [3:0] S_MOD     = 4'd2;
    localparam logic [3:0] S_FILL    = 4'd3;
    localparam logic [3:0] S_MIX_RD  = 4'd4;
    localparam logic [3:0] S_MIX_WR  = 4'd5;
    localparam logic [3:0] S_DRAW_RD = 4'd6;
    localparam logic [3:0] S_DRAW_WR = 4'd7;
    localparam logic [3:0] S_CHK     = 4'd8;
    localparam logic [3:0] S_FRAC    = 4'd9;
    localparam logic [3:0] S_OUT     = 4'd10;

    logic [3:0]         r_state, n_state;
    logic [VAL_W-1:0]   r_modulus, r_seed_offset;
    logic               r_func, n_func;
    logic [SEED_W-1:0]  r_num, n_num;
    logic [VAL_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [PASS_W-1:0]  r_pass, n_pass;
    logic [PTR_W-1:0]   r_pos, n_pos;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [ENTRY_W-1:0] r_cur, n_cur;
    logic [ENTRY_W-1:0] r_prev, n_prev;
    logic [PTR_W-1:0]   r_lead, n_lead;
    logic [PTR_W-1:0]   r_trail, n_trail;
    logic               r_table_ready, n_table_ready;
    logic [WU_W-1:0]    r_wu, n_wu;
    logic [VAL_W-1:0]   r_val, n_val;
    logic [FRAC_W-1:0]  r_frac, n_frac;
    logic               r_out_valid, n_out_valid;
    logic [VAL_W-1:0]   r_out_value, n_out_value;
    logic [FRAC_W-1:0]  r_out_fraction, n_out_fraction;

    logic [MOD_W-1:0]   mod_eff;
    logic [SEED_W-1:0]  off_ext;
    logic [PTR_W:0]     pos_sum;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;
    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;

    // move a lag pointer on, cycling over positions 1..55
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] idx);
        logic [PTR_W-1:0] nxt;
        nxt = (idx >= PTR_W'(TABLE_LEN)) ? PTR_W'(1) : idx + PTR_W'(1);
        return nxt;
    endfunction

    // sign extension of a table entry onto the shared unit
    function automatic logic [ALU_W-1:0] sx(input logic [ENTRY_W-1:0] v);
        return {{(ALU_W - ENTRY_W){v[ENTRY_W-1]}}, v};
    endfunction

    // modulus of zero stands for 2^30
    assign mod_eff = (r_modulus == '0) ? {1'b1, {VAL_W{1'b0}}} : {1'b0, r_modulus};
    assign off_ext = SEED_W'(r_seed_offset);
    assign pos_sum = {1'b0, r_pos} + (PTR_W + 1)'(SPREAD_STRIDE);

    slfr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_LEN)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    slfr_alu u_alu (
        .i_req (alu_req),
        .i_mod (mod_eff),
        .o_rsp (alu_rsp)
    );

    // handshake outputs
    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.value    = r_out_value;
    assign o_out.fraction = r_out_fraction;

    // sequencer
    always_comb begin
        n_state        = r_state;
        n_func         = r_func;
        n_num          = r_num;
        n_rem          = r_rem;
        n_cnt          = r_cnt;
        n_pass         = r_pass;
        n_pos          = r_pos;
        n_j            = r_j;
        n_cur          = r_cur;
        n_prev         = r_prev;
        n_lead         = r_lead;
        n_trail        = r_trail;
        n_table_ready  = r_table_ready;
        n_wu           = r_wu;
        n_val          = r_val;
        n_frac         = r_frac;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_out_value    = r_out_value;
        n_out_fraction = r_out_fraction;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr_a    = '0;
        ram_raddr_b    = '0;
        alu_req.op     = ALU_SUB_MOD;
        alu_req.a      = '0;
        alu_req.b      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_func  = i_in.func;
                    n_num   = (i_in.func == FUNC_SEED) ? i_in.seed_value : '0;
                    n_state = (i_in.func == FUNC_SEED || !r_table_ready) ? S_ABS : S_DRAW_RD;
                end
            end
            // start value |offset - seed|
            S_ABS: begin
                n_num   = (off_ext >= r_num) ? off_ext - r_num : r_num - off_ext;
                n_rem   = '0;
                n_cnt   = CNT_W'(SEED_W - 1);
                n_state = S_MOD;
            end
            // remainder by modulus, one dividend bit a cycle
            S_MOD: begin
                alu_req.op = ALU_DIV_STEP;
                alu_req.a  = ALU_W'({r_rem, r_num[SEED_W-1]});
                n_rem      = alu_rsp.res[VAL_W-1:0];
                n_num      = {r_num[SEED_W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_cur   = ENTRY_W'(alu_rsp.res[VAL_W-1:0]);
                    n_prev  = ENTRY_W'(1);
                    n_pos   = PTR_W'(SPREAD_STRIDE);
                    n_cnt   = '0;
                    n_state = S_FILL;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            // spread over the table with stride 21, last position first
            S_FILL: begin
                ram_we = 1'b1;
                if (r_cnt == '0) begin
                    ram_waddr = IDX_W'(TABLE_LEN - 1);
                    ram_wdata = r_cur;
                end else begin
                    ram_waddr  = IDX_W'(r_pos - PTR_W'(1));
                    ram_wdata  = r_prev;
                    alu_req.op = ALU_SUB_MOD;
                    alu_req.a  = sx(r_cur);
                    alu_req.b  = sx(r_prev);
                    n_prev     = alu_rsp.res[ENTRY_W-1:0];
                    n_cur      = r_prev;
                    n_pos      = (pos_sum >= (PTR_W + 1)'(TABLE_LEN)) ?
                                 PTR_W'(pos_sum - (PTR_W + 1)'(TABLE_LEN)) : PTR_W'(pos_sum);
                end
                if (r_cnt == CNT_W'(TABLE_LEN - 1)) begin
                    n_cnt   = '0;
                    n_j     = IDX_W'(LAG_GAP + 1);
                    n_pass  = '0;
                    n_state = S_MIX_RD;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_MIX_RD: begin
                ram_raddr_a = IDX_W'(r_cnt);
                ram_raddr_b = r_j;
                n_state     = S_MIX_WR;
            end
            // mixing pass: entry i less entry 1 + (i + 30) mod 55
            S_MIX_WR: begin
                alu_req.op = ALU_SUB_MOD;
                alu_req.a  = sx(ram_rdata_a);
                alu_req.b  = sx(ram_rdata_b);
                ram_we     = 1'b1;
                ram_waddr  = IDX_W'(r_cnt);
                ram_wdata  = alu_rsp.res[ENTRY_W-1:0];
                n_state    = S_MIX_RD;
                if (r_cnt == CNT_W'(TABLE_LEN - 1)) begin
                    n_cnt = '0;
                    n_j   = IDX_W'(LAG_GAP + 1);
                    if (r_pass == PASS_W'(MIX_PASSES - 1)) begin
                        n_lead        = '0;
                        n_trail       = PTR_W'(TRAIL_START);
                        n_table_ready = 1'b1;
                        n_wu          = '0;
                        if (r_func == FUNC_SEED) begin
                            n_state = (WARMUP_DRAWS == 0) ? S_IDLE : S_DRAW_RD;
                        end else begin
                            n_state = S_DRAW_RD;
                        end
                    end else begin
                        n_pass = r_pass + PASS_W'(1);
                    end
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                    n_j   = (r_j == IDX_W'(TABLE_LEN - 1)) ? '0 : r_j + IDX_W'(1);
                end
            end
            // draw: advance both lags and fetch
            S_DRAW_RD: begin
                n_lead      = advance(r_lead);
                n_trail     = advance(r_trail);
                ram_raddr_a = IDX_W'(n_lead - PTR_W'(1));
                ram_raddr_b = IDX_W'(n_trail - PTR_W'(1));
                n_state     = S_DRAW_WR;
            end
            S_DRAW_WR: begin
                alu_req.op = ALU_SUB_MOD;
                alu_req.a  = sx(ram_rdata_a);
                alu_req.b  = sx(ram_rdata_b);
                ram_we     = 1'b1;
                ram_waddr  = IDX_W'(r_lead - PTR_W'(1));
                ram_wdata  = alu_rsp.res[ENTRY_W-1:0];
                if (r_func == FUNC_SEED) begin
                    n_wu    = r_wu + WU_W'(1);
                    n_state = (n_wu == WU_W'(WARMUP_DRAWS)) ? S_IDLE : S_DRAW_RD;
                end else begin
                    n_val   = alu_rsp.res[VAL_W-1:0];
                    n_state = S_CHK;
                end
            end
            // value not below modulus: fraction saturates
            S_CHK: begin
                alu_req.op = ALU_DIV_STEP;
                alu_req.a  = ALU_W'(r_val);
                if (alu_rsp.fits) begin
                    n_frac  = '1;
                    n_state = S_OUT;
                end else begin
                    n_rem   = r_val;
                    n_cnt   = CNT_W'(FRAC_W - 1);
                    n_state = S_FRAC;
                end
            end
            // fraction bits by restoring division of value * 2^32
            S_FRAC: begin
                alu_req.op = ALU_DIV_STEP;
                alu_req.a  = ALU_W'({r_rem, 1'b0});
                n_rem      = alu_rsp.res[VAL_W-1:0];
                n_frac     = {r_frac[FRAC_W-2:0], alu_rsp.fits};
                if (r_cnt == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid    = 1'b1;
                    n_out_value    = r_val;
                    n_out_fraction = r_frac;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_modulus     <= MODULUS_RESET;
            r_seed_offset <= SEED_OFFSET_RESET;
            r_lead        <= '0;
            r_trail       <= PTR_W'(TRAIL_START);
            r_table_ready <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_lead        <= n_lead;
            r_trail       <= n_trail;
            r_table_ready <= n_table_ready;
            r_out_valid   <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MODULUS:     r_modulus     <= i_cfg_data;
                    REG_SEED_OFFSET: r_seed_offset <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_func         <= n_func;
        r_num          <= n_num;
        r_rem          <= n_rem;
        r_cnt          <= n_cnt;
        r_pass         <= n_pass;
        r_pos          <= n_pos;
        r_j            <= n_j;
        r_cur          <= n_cur;
        r_prev         <= n_prev;
        r_wu           <= n_wu;
        r_val          <= n_val;
        r_frac         <= n_frac;
        r_out_value    <= n_out_value;
        r_out_fraction <= n_out_fraction;
    end

`ifndef SYNTHESIS
    // lag pointers stay inside the table and never coincide
    a_lag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lead <= PTR_W'(TABLE_LEN) && r_trail <= PTR_W'(TABLE_LEN) && r_lead != r_trail)
        else $error("lag pointers out of range");

    // draws only run on a built table
    a_draw_built: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DRAW_RD |-> r_table_ready)
        else $error("draw on an unbuilt table");

    // a result is only presented from the output state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result without a completed draw");

    // the spread walk never runs past the table
    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FILL |-> r_cnt < CNT_W'(TABLE_LEN) && r_pos != '0)
        else $error("spread walk out of range");
`endif
endmodule

// File: hdl/slfr_ram.sv
// generic ram: one write port, two registered read ports
`timescale 1ns / 1ps

module slfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 55
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

// File: hdl/slfr_alu.sv
// shared subtract unit: modular difference or one restoring division step
`timescale 1ns / 1ps

module slfr_alu (
    input  slfr_pkg::t_alu_req          i_req,
    input  logic [slfr_pkg::MOD_W-1:0]  i_mod,
    output slfr_pkg::t_alu_rsp          o_rsp
);
    import slfr_pkg::*;

    logic [ALU_W-1:0] mod_ext;
    logic [ALU_W-1:0] rhs;
    logic [ALU_W-1:0] diff;
    logic             neg;

    // one subtractor, then add-back or restore on a negative difference
    always_comb begin
        mod_ext = ALU_W'(i_mod);
        rhs     = (i_req.op == ALU_DIV_STEP) ? mod_ext : i_req.b;
        diff    = i_req.a - rhs;
        neg     = diff[ALU_W-1];
        o_rsp.fits = !neg;
        if (!neg) begin
            o_rsp.res = diff;
        end else if (i_req.op == ALU_SUB_MOD) begin
            o_rsp.res = diff + mod_ext;
        end else begin
            o_rsp.res = i_req.a;
        end
    end
endmodule
